[design/u2u8_pkg.sv]
`timescale 1ns / 1ps
package u2u8_pkg;

   localparam int CP_WIDTH = 21;

   localparam logic [5:0]  HIGH_TAG = 6'b110110;
   localparam logic [5:0]  LOW_TAG = 6'b110111;
   localparam logic [15:0] CARRIAGE_RETURN = 16'h000D;
   localparam logic [CP_WIDTH-1:0] REPLACEMENT_POINT = 21'h00FFFD;
   localparam logic [CP_WIDTH-1:0] PAIR_OFFSET = 21'h010000;
   localparam logic [CP_WIDTH-1:0] ONE_BYTE_LIMIT = 21'h000080;
   localparam logic [CP_WIDTH-1:0] TWO_BYTE_LIMIT = 21'h000800;
   localparam logic [CP_WIDTH-1:0] BMP_TOP = 21'h00FFFF;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        final_unit;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_replacement;
      logic       end_of_char;
   } rsp_type;

   typedef struct packed {
      logic [CP_WIDTH-1:0] cp;
      logic                repl;
   } point_type;

   function automatic logic [2:0] byte_count(input logic [CP_WIDTH-1:0] cp);
      logic [2:0] n;
      if (cp < ONE_BYTE_LIMIT) begin
         n = 3'd1;
      end else if (cp < TWO_BYTE_LIMIT) begin
         n = 3'd2;
      end else if (cp <= BMP_TOP) begin
         n = 3'd3;
      end else begin
         n = 3'd4;
      end
      return n;
   endfunction

   function automatic logic [7:0] encode_byte(input logic [CP_WIDTH-1:0] cp,
                                              input logic [2:0] n,
                                              input logic [1:0] k);
      logic [7:0] b;
      case ({n, k})
         5'b001_00: b = cp[7:0];
         5'b010_00: b = {3'b110, cp[10:6]};
         5'b010_01: b = {2'b10, cp[5:0]};
         5'b011_00: b = {4'b1110, cp[15:12]};
         5'b011_01: b = {2'b10, cp[11:6]};
         5'b011_10: b = {2'b10, cp[5:0]};
         5'b100_00: b = {5'b11110, cp[20:18]};
         5'b100_01: b = {2'b10, cp[17:12]};
         5'b100_10: b = {2'b10, cp[11:6]};
         5'b100_11: b = {2'b10, cp[5:0]};
         default:   b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

[design/u2u8_front.sv]
`timescale 1ns / 1ps
module u2u8_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  u2u8_pkg::req_type   req_data,
   output logic                req_ready,
   output logic                push_valid,
   output u2u8_pkg::point_type push_data,
   input  logic                push_ready
);
   import u2u8_pkg::*;

   logic [9:0] held_ff, held_in;
   logic       pend_ff, pend_in;
   logic       emit;
   logic       is_low, is_high;
   logic       accept;
   point_type  point;

   assign is_low  = (req_data.code_unit[15:10] == LOW_TAG);
   assign is_high = (req_data.code_unit[15:10] == HIGH_TAG);

   always_comb begin
      held_in = held_ff;
      pend_in = pend_ff;
      emit = 1'b0;
      point.cp = {5'b0, req_data.code_unit};
      point.repl = 1'b0;
      if (pend_ff) begin
         pend_in = 1'b0;
         held_in = 10'd0;
         emit = 1'b1;
         if (is_low) begin
            point.cp = {1'b0, held_ff, req_data.code_unit[9:0]} + PAIR_OFFSET;
         end else begin
            point.cp = REPLACEMENT_POINT;
            point.repl = 1'b1;
         end
      end else if (is_high) begin
         if (req_data.final_unit) begin
            emit = 1'b1;
            point.cp = REPLACEMENT_POINT;
            point.repl = 1'b1;
         end else begin
            pend_in = 1'b1;
            held_in = req_data.code_unit[9:0];
         end
      end else if (is_low) begin
         emit = 1'b1;
         point.cp = REPLACEMENT_POINT;
         point.repl = 1'b1;
      end else begin
         emit = (req_data.code_unit != CARRIAGE_RETURN);
      end
   end

   assign req_ready  = push_ready;
   assign accept     = req_valid && push_ready;
   assign push_valid = req_valid && emit;
   assign push_data  = point;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         held_ff <= 10'd0;
      end else if (accept) begin
         pend_ff <= pend_in;
         held_ff <= held_in;
      end
   end

endmodule

[design/u2u8_queue.sv]
`timescale 1ns / 1ps
module u2u8_queue #(
   parameter int DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  u2u8_pkg::point_type in_data,
   output logic                in_ready,
   output logic                out_valid,
   output u2u8_pkg::point_type out_data,
   input  logic                out_ready
);
   import u2u8_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   point_type        slot_ff [DEPTH];
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign in_ready  = (count_ff != FULL_CNT);
   assign out_valid = (count_ff != '0);
   assign out_data  = slot_ff[head_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in = (tail_ff == LAST_PTR) ? '0 : tail_ff + 1'b1;
      end
      if (pop) begin
         head_in = (head_ff == LAST_PTR) ? '0 : head_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         count_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         count_ff <= count_in;
      end
      if (push) begin
         slot_ff[tail_ff] <= in_data;
      end
   end

endmodule

[design/u2u8_back.sv]
`timescale 1ns / 1ps
module u2u8_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   input  u2u8_pkg::point_type pop_data,
   output logic                pop_ready,
   output logic                rsp_valid,
   output u2u8_pkg::rsp_type   rsp_data,
   input  logic                rsp_ready
);
   import u2u8_pkg::*;

   point_type  cur_ff, cur_in;
   logic       cur_valid_ff, cur_valid_in;
   logic [1:0] idx_ff, idx_in;
   logic       out_valid_ff, out_valid_in;
   rsp_type    out_ff, out_in;
   logic [2:0] cnt;
   logic       last;
   logic       load_out;

   assign cnt = byte_count(cur_ff.cp);
   assign last = ({1'b0, idx_ff} == (cnt - 3'd1));
   assign load_out = cur_valid_ff && (!out_valid_ff || rsp_ready);
   assign pop_ready = !cur_valid_ff || (load_out && last);

   always_comb begin
      cur_in = cur_ff;
      cur_valid_in = cur_valid_ff;
      idx_in = idx_ff;
      out_valid_in = out_valid_ff;
      out_in = out_ff;
      if (load_out) begin
         out_valid_in = 1'b1;
         out_in.out_byte = encode_byte(cur_ff.cp, cnt, idx_ff);
         out_in.is_replacement = cur_ff.repl;
         out_in.end_of_char = last;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (pop_valid && pop_ready) begin
         cur_in = pop_data;
         cur_valid_in = 1'b1;
         idx_in = 2'd0;
      end else if (load_out && last) begin
         cur_valid_in = 1'b0;
      end else if (load_out) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff <= idx_in;
         out_valid_ff <= out_valid_in;
      end
      cur_ff <= cur_in;
      out_ff <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

`ifndef SYNTH
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> ({1'b0, idx_ff} < cnt))
      else $error("byte index beyond code point length");

   a_repl_bytes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.is_replacement) |->
         (rsp_data.out_byte == 8'hEF || rsp_data.out_byte == 8'hBF ||
          rsp_data.out_byte == 8'hBD))
      else $error("replacement beat is not part of EF BF BD");

   a_continuation: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_data.end_of_char) |=>
         (rsp_valid && rsp_data.out_byte[7:6] == 2'b10))
      else $error("missing continuation beat");

   a_lead_after_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_data.end_of_char) |=>
         (!rsp_valid || rsp_data.out_byte[7:6] != 2'b10))
      else $error("continuation beat without lead byte");
`endif

endmodule

[design/utf16_to_utf8_cr_strip_decoder_top.sv]
`timescale 1ns / 1ps
// UTF-16 to UTF-8 transcoder with carriage-return removal.
// Input channel req_*: one UTF-16 code unit per beat plus a final-unit flag.
// Output channel rsp_*: one UTF-8 byte per beat, with a flag for bytes of an
// error replacement U+FFFD and a flag on the last byte of each code point.
// A high surrogate is held inside until the following unit arrives; a unit
// that completes no code point, or a carriage return, produces no beats.
// The first byte of a code point passes the point queue slot, the serializer
// holding register and the byte output register before it is offered on rsp_*.
// Throughput: one output byte per cycle while rsp_ready stays high, set by the
// single serializer in the back end; it sends the 1 to 4 bytes of a code point
// in order and only then takes another point from the queue.
// A queue of QUEUE_DEPTH code points separates the front from the serializer,
// so units keep being accepted while the receiver stalls until it fills;
// then req_ready drops and all data is held.
// Reset (synchronous, active high) drops any held surrogate, empties the
// queue and clears rsp_valid.
module utf16_to_utf8_cr_strip_decoder_top #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  u2u8_pkg::req_type req_data,
   output logic              req_ready,
   output logic              rsp_valid,
   output u2u8_pkg::rsp_type rsp_data,
   input  logic              rsp_ready
);
   import u2u8_pkg::*;

   logic      push_valid, push_ready;
   point_type push_data;
   logic      pop_valid, pop_ready;
   point_type pop_data;

   u2u8_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_data   (req_data),
      .req_ready  (req_ready),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready)
   );

   u2u8_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_data   (push_data),
      .in_ready  (push_ready),
      .out_valid (pop_valid),
      .out_data  (pop_data),
      .out_ready (pop_ready)
   );

   u2u8_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_data  (pop_data),
      .pop_ready (pop_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_ready (rsp_ready)
   );

endmodule

[test/utf8_stream_checker.sv]
`timescale 1ns / 1ps
module utf8_stream_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  u2u8_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  u2u8_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                bytes_pending
);
   import u2u8_pkg::*;

   rsp_type utf8_due[$];
   logic [9:0] held_bits;
   logic held_valid;

   task automatic queue_point(input logic [CP_WIDTH-1:0] cp, input logic repl);
      logic [7:0] seq[4];
      int n;
      rsp_type b;
      if (cp == CP_WIDTH'(CARRIAGE_RETURN)) begin
         return;
      end
      if (cp < 21'h80) begin
         seq[0] = cp[7:0];
         n = 1;
      end else if (cp < 21'h800) begin
         seq[0] = 8'hC0 | 8'(cp >> 6);
         seq[1] = 8'h80 | 8'(cp & 21'h3F);
         n = 2;
      end else if (cp < 21'h10000) begin
         seq[0] = 8'hE0 | 8'(cp >> 12);
         seq[1] = 8'h80 | 8'((cp >> 6) & 21'h3F);
         seq[2] = 8'h80 | 8'(cp & 21'h3F);
         n = 3;
      end else begin
         seq[0] = 8'hF0 | 8'((cp >> 18) & 21'h07);
         seq[1] = 8'h80 | 8'((cp >> 12) & 21'h3F);
         seq[2] = 8'h80 | 8'((cp >> 6) & 21'h3F);
         seq[3] = 8'h80 | 8'(cp & 21'h3F);
         n = 4;
      end
      for (int k = 0; k < n; k++) begin
         b.out_byte = seq[k];
         b.is_replacement = repl;
         b.end_of_char = (k == n - 1);
         utf8_due.push_back(b);
      end
   endtask

   task automatic transcode_unit(input req_type beat);
      logic is_low;
      logic is_high;
      logic [9:0] hi;
      is_low = beat.code_unit[15:10] == LOW_TAG;
      is_high = beat.code_unit[15:10] == HIGH_TAG;
      if (held_valid) begin
         hi = held_bits;
         held_valid = 1'b0;
         held_bits = '0;
         if (is_low) begin
            queue_point({1'b0, hi, beat.code_unit[9:0]} + PAIR_OFFSET, 1'b0);
         end else begin
            queue_point(REPLACEMENT_POINT, 1'b1);
         end
      end else if (is_high) begin
         if (beat.final_unit) begin
            queue_point(REPLACEMENT_POINT, 1'b1);
         end else begin
            held_bits = beat.code_unit[9:0];
            held_valid = 1'b1;
         end
      end else if (is_low) begin
         queue_point(REPLACEMENT_POINT, 1'b1);
      end else begin
         queue_point(CP_WIDTH'(beat.code_unit), 1'b0);
      end
   endtask

   initial begin
      fail_count = 0;
      bytes_pending = 0;
      held_bits = '0;
      held_valid = 1'b0;
   end

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         held_bits = '0;
         held_valid = 1'b0;
         utf8_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (utf8_due.size() == 0) begin
               $error("unexpected beat: out_byte %h", rsp_data.out_byte);
               fail_count++;
            end else begin
               want = utf8_due.pop_front();
               if (rsp_data.out_byte !== want.out_byte) begin
                  $error("out_byte expected %h actual %h", want.out_byte, rsp_data.out_byte);
                  fail_count++;
               end
               if (rsp_data.is_replacement !== want.is_replacement) begin
                  $error("is_replacement expected %b actual %b",
                         want.is_replacement, rsp_data.is_replacement);
                  fail_count++;
               end
               if (rsp_data.end_of_char !== want.end_of_char) begin
                  $error("end_of_char expected %b actual %b",
                         want.end_of_char, rsp_data.end_of_char);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            transcode_unit(req_data);
         end
      end
      bytes_pending = utf8_due.size();
   end

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
   import u2u8_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid;
   req_type req_data;
   logic    req_ready;
   logic    rsp_valid;
   rsp_type rsp_data;
   logic    rsp_ready;
   int      fail_count;
   int      bytes_pending;
   logic    steady = 1'b0;
   logic    hold_request = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   utf16_to_utf8_cr_strip_decoder_top DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_data(req_data),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data),
      .rsp_ready(rsp_ready)
   );

   utf8_stream_checker checker_i (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .fail_count(fail_count),
      .bytes_pending(bytes_pending)
   );

   task automatic send_unit(input logic [15:0] unit, input logic fin);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data <= '{code_unit: unit, final_unit: fin};
      req_valid <= 1'b1;
      do @(posedge clock); while (!(req_valid && req_ready));
      @(negedge clock);
   endtask

   function automatic logic [15:0] bmp_unit();
      return ($urandom_range(0, 1) == 0) ? 16'($urandom_range(16'h0800, 16'hD7FF))
                                         : 16'($urandom_range(16'hE000, 16'hFFFF));
   endfunction

   // receiver: random stall per beat, one long hold on request
   initial begin
      int wait_cycles;
      rsp_ready <= 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (300) @(negedge clock);
            hold_request = 1'b0;
         end
         wait_cycles = steady ? 0 : $urandom_range(0, 16);
         if (wait_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (wait_cycles) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         @(negedge clock);
      end
   end

   initial begin
      int sent;
      int pick;
      logic fin;
      req_valid <= 1'b0;
      req_data <= '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_unit(16'h0000, 1'b0);
      send_unit(16'h007F, 1'b0);
      send_unit(16'h0080, 1'b0);
      send_unit(16'h07FF, 1'b0);
      send_unit(16'h0800, 1'b1);
      send_unit(16'hFFFF, 1'b0);
      send_unit(16'hFFFD, 1'b0);
      send_unit(CARRIAGE_RETURN, 1'b0);
      send_unit(16'hDC00, 1'b0);
      send_unit(16'hDFFF, 1'b1);
      send_unit(16'hD800, 1'b0);
      send_unit(16'hDC00, 1'b0);
      send_unit(16'hDBFF, 1'b0);
      send_unit(16'hDFFF, 1'b1);
      send_unit(16'hD800, 1'b0);
      send_unit(16'h0041, 1'b0);
      send_unit(16'hD83D, 1'b0);
      send_unit(16'hDBFF, 1'b0);
      send_unit(16'hD801, 1'b0);
      send_unit(CARRIAGE_RETURN, 1'b0);
      send_unit(16'hDBFF, 1'b1);
      send_unit(16'hD800, 1'b0);
      send_unit(16'hE000, 1'b1);
      send_unit(16'hD7FF, 1'b0);
      send_unit(16'h000A, 1'b1);

      sent = 0;
      while (sent < 280) begin
         if (sent % 40 == 0) begin
            steady = ($urandom_range(0, 3) == 0);
         end
         if (sent >= 100 && sent < 102) begin
            hold_request = 1'b1;
            steady = 1'b1;
         end
         fin = ($urandom_range(0, 9) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 25) begin
            send_unit(16'($urandom_range(0, 16'h007F)), fin);
            sent += 1;
         end else if (pick < 40) begin
            send_unit(16'($urandom_range(16'h0080, 16'h07FF)), fin);
            sent += 1;
         end else if (pick < 58) begin
            send_unit(bmp_unit(), fin);
            sent += 1;
         end else if (pick < 80) begin
            send_unit(16'hD800 | 16'($urandom_range(0, 16'h03FF)), 1'b0);
            send_unit(16'hDC00 | 16'($urandom_range(0, 16'h03FF)), fin);
            sent += 2;
         end else if (pick < 85) begin
            send_unit(16'hDC00 | 16'($urandom_range(0, 16'h03FF)), fin);
            sent += 1;
         end else if (pick < 90) begin
            send_unit(16'hD800 | 16'($urandom_range(0, 16'h03FF)), fin);
            send_unit(16'($urandom_range(0, 16'hFFFF)), 1'($urandom_range(0, 1)));
            sent += 2;
         end else if (pick < 94) begin
            send_unit(CARRIAGE_RETURN, fin);
            sent += 1;
         end else begin
            send_unit(16'($urandom_range(0, 16'hFFFF)), fin);
            sent += 1;
         end
      end
      req_valid <= 1'b0;
      steady = 1'b0;

      wait (bytes_pending == 0);
      repeat (30) @(negedge clock);
      if (fail_count == 0 && bytes_pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("tb: failure");
      $finish;
   end

endmodule
